@@ design/bmsi_pkg.sv @@
// shared types and constants for the bank mapper core
package bmsi_pkg;

  localparam int unsigned ChrBankBitsDefault = 8;
  localparam int unsigned PrgBankBitsDefault = 6;

  // target codes
  localparam logic [2:0] TgtChr  = 3'd0;
  localparam logic [2:0] TgtNt   = 3'd1;
  localparam logic [2:0] TgtWram = 3'd2;
  localparam logic [2:0] TgtPrg  = 3'd3;
  localparam logic [2:0] TgtNone = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CfgChrCount = 2'd0;
  localparam logic [1:0] CfgPrgCount = 2'd1;
  localparam logic [1:0] CfgRamPres  = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [15:0] address;
    logic [7:0]  value;
  } bmsi_req_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [18:0] mapped_address;
    logic        irq;
    logic        mirror_select;
  } bmsi_rsp_t;

endpackage

@@ design/bank_mapper_with_scanline_irq_core.sv @@
// bank mapper core with scanline interrupt counter and serial bank reduction
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid_i/stall_o  | bmsi_req_t (mode, address, value)
//  rsp     | out       | rsp_valid_o/stall_i  | bmsi_rsp_t (target, mapped_address, irq, mirror)
//  cfg     | in        | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// a taken request passes the divide state, then the output state registers the response;
// a bank data write stays in the divide state while the modulo by the bank count runs,
// one quotient bit per cycle through a shared subtractor; one request is in flight at a time
// reset loads program slots 0, 1, count-2, count-1 and clears the rest
// the response register holds until taken; rsp_stall_i holds off the next request
module bank_mapper_with_scanline_irq_core #(
  parameter int unsigned CHR_BANK_BITS = bmsi_pkg::ChrBankBitsDefault,
  parameter int unsigned PRG_BANK_BITS = bmsi_pkg::PrgBankBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  bmsi_pkg::bmsi_req_t req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_stall_i,
  output bmsi_pkg::bmsi_rsp_t rsp_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [8:0]          cfg_data_i
);
  import bmsi_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  localparam logic [CHR_BANK_BITS-1:0] ChrMask = {CHR_BANK_BITS{1'b1}};
  localparam logic [PRG_BANK_BITS-1:0] PrgMask = {PRG_BANK_BITS{1'b1}};

  logic [1:0] state_q, state_d;
  bmsi_req_t  req_q;
  logic [8:0] chr_cnt_q;
  logic [6:0] prg_cnt_q;
  logic       ram_q;
  logic [7:0] bank_sel_q;
  logic [CHR_BANK_BITS-1:0] chr_bank_q [8];
  logic [PRG_BANK_BITS-1:0] prg_bank_q [4];
  logic       mirror_q;
  logic [7:0] latch_q, count_q;
  logic       reload_q, enable_q, a12_q, irq_q;
  logic [8:0] rem_q, rem_d;
  logic [2:0] bit_q;
  logic       rsp_valid_q;
  bmsi_rsp_t  rsp_q;

  // request decode
  logic [2:0] region;
  logic       is_bank_data, is_chr_sel;
  logic [8:0] divisor;
  logic [7:0] dividend;
  logic [9:0] trial;
  logic [7:0] red;
  logic [6:0] prg_m2;

  assign region       = req_q.address[15:13];
  assign is_chr_sel   = (bank_sel_q[2:0] <= 3'd5);
  assign is_bank_data = req_q.mode && (region == 3'd4) && req_q.address[0];
  assign divisor      = is_chr_sel ? chr_cnt_q : {2'b0, prg_cnt_q};
  assign dividend     = is_chr_sel ? req_q.value : {2'b00, req_q.value[5:0]};
  assign prg_m2       = prg_cnt_q - 7'd2;
  assign req_stall_o  = (state_q != StIdle) || rsp_valid_q;

  // shared restoring subtractor: one quotient bit per cycle
  assign trial = {rem_q, dividend[bit_q]} - {1'b0, divisor};
  always_comb begin
    rem_d = {rem_q[7:0], dividend[bit_q]};
    if (!trial[9]) rem_d = trial[8:0];
  end
  assign red = (divisor == 9'd0) ? dividend : rem_q[7:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (req_valid_i && !req_stall_o) state_d = StDiv;
      StDiv:  if (!is_bank_data || bit_q == 3'd0) state_d = StOut;
      StOut:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture and division state
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && req_valid_i && !req_stall_o) begin
      req_q <= req_i;
      rem_q <= 9'd0;
      bit_q <= 3'd7;
    end else if (state_q == StDiv && is_bank_data) begin
      rem_q <= rem_d;
      bit_q <= bit_q - 3'd1;
    end
  end

  // mapper state update and response
  logic        do_out;
  logic [7:0]  prg_red;
  assign do_out  = (state_q == StOut);
  assign prg_red = red;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_cnt_q  <= 9'd256;
      prg_cnt_q  <= 7'd64;
      ram_q      <= 1'b1;
      bank_sel_q <= 8'd0;
      for (int i = 0; i < 8; i++) chr_bank_q[i] <= '0;
      prg_bank_q[0] <= '0;
      prg_bank_q[1] <= PRG_BANK_BITS'(1) & PrgMask;
      prg_bank_q[2] <= PRG_BANK_BITS'(7'd62);
      prg_bank_q[3] <= PRG_BANK_BITS'(7'd63);
      mirror_q <= 1'b0;
      latch_q  <= 8'd0;
      count_q  <= 8'd0;
      reload_q <= 1'b0;
      enable_q <= 1'b0;
      a12_q    <= 1'b0;
      irq_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && !rsp_stall_i) rsp_valid_q <= 1'b0;
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgChrCount: chr_cnt_q <= cfg_data_i;
          CfgPrgCount: begin
            prg_cnt_q     <= cfg_data_i[6:0];
            prg_bank_q[0] <= '0;
            prg_bank_q[1] <= PRG_BANK_BITS'(1) & PrgMask;
            prg_bank_q[2] <= PRG_BANK_BITS'(cfg_data_i[6:0] - 7'd2);
            prg_bank_q[3] <= PRG_BANK_BITS'(cfg_data_i[6:0] - 7'd1);
          end
          CfgRamPres: ram_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (do_out) begin
        logic       n_irq;
        logic [2:0] tgt;
        logic [18:0] map;
        logic [2:0] slot;
        logic [1:0] poff;
        n_irq = irq_q;
        tgt   = TgtNone;
        map   = '0;
        slot  = '0;
        poff  = '0;
        case (region)
          3'd0: begin
            tgt = TgtChr;
            map = 19'({chr_bank_q[req_q.address[12:10]], req_q.address[9:0]});
            if (!req_q.mode) begin
              a12_q <= req_q.address[12];
              if (req_q.address[12] && !a12_q) begin
                if (reload_q) begin
                  count_q  <= latch_q;
                  reload_q <= 1'b0;
                end else if (count_q == 8'd1) begin
                  count_q <= 8'd0;
                  if (enable_q) n_irq = 1'b1;
                end else if (count_q == 8'd0) begin
                  count_q <= latch_q;
                end else begin
                  count_q <= count_q - 8'd1;
                end
              end
            end
          end
          3'd1: begin
            tgt = TgtNt;
            map = 19'(req_q.address[11:0]);
          end
          3'd2: ;
          3'd3: if (ram_q) begin
            tgt = TgtWram;
            map = 19'(req_q.address[12:0]);
          end
          default: begin
            if (req_q.mode) begin
              case (region)
                3'd4: begin
                  if (!req_q.address[0]) begin
                    bank_sel_q <= req_q.value;
                  end else if (bank_sel_q[2:0] <= 3'd1) begin
                    slot = {bank_sel_q[7], bank_sel_q[0], 1'b0};
                    chr_bank_q[slot]        <= CHR_BANK_BITS'(red & 8'hFE) & ChrMask;
                    chr_bank_q[slot | 3'd1] <= CHR_BANK_BITS'(red | 8'h01) & ChrMask;
                  end else if (bank_sel_q[2:0] <= 3'd5) begin
                    slot = {~bank_sel_q[7], 2'(bank_sel_q[2:0] - 3'd2)};
                    chr_bank_q[slot] <= CHR_BANK_BITS'(red);
                  end else if (bank_sel_q[2:0] == 3'd6) begin
                    poff = bank_sel_q[6] ? 2'd2 : 2'd0;
                    prg_bank_q[2'd0 ^ poff] <= PRG_BANK_BITS'(prg_red);
                    prg_bank_q[2'd2 ^ poff] <= PRG_BANK_BITS'(prg_m2);
                  end else begin
                    prg_bank_q[1] <= PRG_BANK_BITS'(prg_red);
                  end
                end
                3'd5: if (!req_q.address[0]) mirror_q <= req_q.value[0];
                3'd6: begin
                  if (req_q.address[0]) reload_q <= 1'b1;
                  else latch_q <= req_q.value;
                end
                default: begin
                  if (req_q.address[0]) begin
                    enable_q <= 1'b1;
                  end else begin
                    enable_q <= 1'b0;
                    n_irq    = 1'b0;
                  end
                end
              endcase
            end else begin
              tgt = TgtPrg;
              map = 19'({prg_bank_q[region[1:0]], req_q.address[12:0]});
            end
          end
        endcase
        irq_q       <= n_irq;
        rsp_q       <= '{target: tgt, mapped_address: map, irq: n_irq,
                         mirror_select: (req_q.mode && region == 3'd5 &&
                                         !req_q.address[0]) ? req_q.value[0]
                                                            : mirror_q};
        rsp_valid_q <= 1'b1;
      end
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> req_stall_o) else $error("accept while busy");
  a_out_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |=> rsp_valid_q) else $error("missing response");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && is_bank_data && divisor != 9'd0) |-> (rem_q < divisor))
    else $error("remainder out of range");
  a_irq_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(irq_q) |-> $past(enable_q)) else $error("irq without enable");
endmodule

@@ bench/bank_mapper_with_scanline_irq_core_tb.sv @@
// testbench for the bank mapper core: directed and random bus requests checked against a model
`timescale 1ns / 1ps

module bank_mapper_with_scanline_irq_core_tb;
  import bmsi_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  // bus access model plus queue of expected responses
  class mapper_scoreboard;
    int unsigned chr_count;
    int unsigned prg_count;
    bit          ram_on;
    logic [7:0]  sel_q;
    logic [7:0]  chr_bank_q [8];
    logic [5:0]  prg_bank_q [4];
    bit          mirror_q;
    logic [7:0]  latch_q;
    logic [7:0]  count_q;
    bit          reload_q;
    bit          enable_q;
    bit          a12_q;
    bit          irq_q;
    bmsi_rsp_t   pending_q [$];
    int unsigned errors;

    function void reset_state();
      chr_count = 256;
      prg_count = 64;
      ram_on    = 1'b1;
      sel_q     = '0;
      foreach (chr_bank_q[i]) chr_bank_q[i] = '0;
      load_prg();
      mirror_q  = 1'b0;
      latch_q   = '0;
      count_q   = '0;
      reload_q  = 1'b0;
      enable_q  = 1'b0;
      a12_q     = 1'b0;
      irq_q     = 1'b0;
      pending_q.delete();
      errors    = 0;
    endfunction

    function void load_prg();
      prg_bank_q[0] = 6'd0;
      prg_bank_q[1] = 6'd1;
      prg_bank_q[2] = 6'(prg_count - 2);
      prg_bank_q[3] = 6'(prg_count - 1);
    endfunction

    function void set_reg(logic [1:0] idx, logic [8:0] data);
      if (idx == CfgChrCount) begin
        chr_count = data;
      end else if (idx == CfgPrgCount) begin
        prg_count = data[6:0];
        load_prg();
      end else if (idx == CfgRamPres) begin
        ram_on = data[0];
      end
    endfunction

    function int unsigned wrap(int unsigned v, int unsigned n);
      return (n == 0) ? v : v % n;
    endfunction

    function void clock_counter(bit a12);
      if (a12 && !a12_q) begin
        if (reload_q) begin
          count_q  = latch_q;
          reload_q = 1'b0;
        end else if (count_q == 8'd1) begin
          count_q = '0;
          if (enable_q) irq_q = 1'b1;
        end else if (count_q == 8'd0) begin
          count_q = latch_q;
        end else begin
          count_q = count_q - 8'd1;
        end
      end
      a12_q = a12;
    endfunction

    function void bank_write(logic [7:0] v);
      int unsigned r;
      int unsigned b;
      int unsigned slot;
      int unsigned off;
      r = sel_q[2:0];
      if (r <= 1) begin
        b = wrap(v, chr_count);
        slot = (sel_q[7] ? 4 : 0) | (r << 1);
        chr_bank_q[slot]     = 8'(b & 'hFE);
        chr_bank_q[slot | 1] = 8'(b | 1);
      end else if (r <= 5) begin
        b = wrap(v, chr_count);
        slot = (sel_q[7] ? 0 : 4) | (r - 2);
        chr_bank_q[slot] = 8'(b);
      end else if (r == 6) begin
        off = sel_q[6] ? 2 : 0;
        prg_bank_q[0 ^ off] = 6'(wrap(v & 'h3F, prg_count));
        prg_bank_q[2 ^ off] = 6'(prg_count - 2);
      end else begin
        prg_bank_q[1] = 6'(wrap(v & 'h3F, prg_count));
      end
    endfunction

    function void reg_write(logic [15:0] a, logic [7:0] v);
      case (a[15:13])
        3'd4: if (a[0]) bank_write(v); else sel_q = v;
        3'd5: if (!a[0]) mirror_q = v[0];
        3'd6: if (a[0]) reload_q = 1'b1; else latch_q = v;
        default: begin
          if (a[0]) begin
            enable_q = 1'b1;
          end else begin
            enable_q = 1'b0;
            irq_q    = 1'b0;
          end
        end
      endcase
    endfunction

    // note an accepted request and queue its response
    function void note_request(bmsi_req_t rq);
      bmsi_rsp_t rs;
      rs.target = TgtNone;
      rs.mapped_address = '0;
      case (rq.address[15:13])
        3'd0: begin
          rs.target = TgtChr;
          rs.mapped_address = {1'b0, chr_bank_q[rq.address[12:10]], rq.address[9:0]};
          if (!rq.mode) clock_counter(rq.address[12]);
        end
        3'd1: begin
          rs.target = TgtNt;
          rs.mapped_address = 19'(rq.address[11:0]);
        end
        3'd2: ;
        3'd3: begin
          if (ram_on) begin
            rs.target = TgtWram;
            rs.mapped_address = 19'(rq.address[12:0]);
          end
        end
        default: begin
          if (rq.mode) begin
            reg_write(rq.address, rq.value);
          end else begin
            rs.target = TgtPrg;
            rs.mapped_address = {prg_bank_q[rq.address[14:13]], rq.address[12:0]};
          end
        end
      endcase
      rs.irq = irq_q;
      rs.mirror_select = mirror_q;
      pending_q.push_back(rs);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    // compare a response with the oldest expectation
    task check_response(bmsi_rsp_t rs);
      bmsi_rsp_t ex;
      if (pending_q.size() == 0) begin
        report("unexpected response", rs, 0);
      end else begin
        ex = pending_q.pop_front();
        if (rs.target !== ex.target) report("target", rs.target, ex.target);
        if (rs.mapped_address !== ex.mapped_address)
          report("mapped_address", rs.mapped_address, ex.mapped_address);
        if (rs.irq !== ex.irq) report("irq", rs.irq, ex.irq);
        if (rs.mirror_select !== ex.mirror_select)
          report("mirror_select", rs.mirror_select, ex.mirror_select);
      end
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      req_valid;
  logic      req_stall;
  bmsi_req_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  bmsi_rsp_t rsp;
  logic      cfg_we;
  logic [1:0] cfg_idx;
  logic [8:0] cfg_data;

  mapper_scoreboard board;
  int unsigned idle_cycles;
  int unsigned stall_mode;

  bank_mapper_with_scanline_irq_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_stall_o (req_stall),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_stall_i (rsp_stall),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side: stall pattern, check, request notes and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_valid && !rsp_stall) board.check_response(rsp);
      if (req_valid && !req_stall) board.note_request(req);
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        2: rsp_stall <= ($urandom_range(0, 1) == 0);
        default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // send one request, holding it until taken
  task send_request(logic m, logic [15:0] a, logic [7:0] v);
    req_valid <= 1'b1;
    req <= '{mode: m, address: a, value: v};
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task pause_sender();
    int unsigned n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
    if (n != 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [8:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    board.set_reg(idx, data);
  endtask

  // random access weighted toward mapper registers and character reads
  task random_request();
    logic [15:0] a;
    logic        m;
    int unsigned k;
    k = $urandom_range(0, 9);
    a = 16'($urandom);
    m = $urandom_range(0, 1);
    if (k < 3) begin
      a[15] = 1'b1;
      m = 1'b1;
    end else if (k < 6) begin
      a[15:13] = 3'd0;
      m = ($urandom_range(0, 4) == 0);
    end else if (k < 8) begin
      a[15] = 1'b1;
      m = 1'b0;
    end
    send_request(m, a, 8'($urandom));
  endtask

  task random_phase(int unsigned n);
    int unsigned burst;
    while (n > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && n > 0) begin
        random_request();
        burst--;
        n--;
      end
      pause_sender();
    end
  endtask

  initial begin
    board = new();
    board.reset_state();
    rst_n = 1'b0;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgChrCount;
    cfg_data = '0;
    idle_cycles = 0;
    stall_mode = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: regions, bank data in selects 0, 5, 6 and 7, counter and irq
    send_request(1'b0, 16'h0000, 8'h00);
    send_request(1'b0, 16'hFFFF, 8'hFF);
    send_request(1'b1, 16'h8000, 8'hC6);
    send_request(1'b1, 16'h8001, 8'hFF);
    send_request(1'b1, 16'h8000, 8'h07);
    send_request(1'b1, 16'h8001, 8'h3F);
    send_request(1'b1, 16'h8000, 8'h80);
    send_request(1'b1, 16'h8001, 8'hFF);
    send_request(1'b1, 16'h8000, 8'h05);
    send_request(1'b1, 16'h8001, 8'hAB);
    send_request(1'b1, 16'hA000, 8'h01);
    send_request(1'b1, 16'hA001, 8'hFF);
    send_request(1'b1, 16'hC000, 8'h02);
    send_request(1'b1, 16'hC001, 8'h00);
    send_request(1'b1, 16'hE001, 8'h00);
    for (int i = 0; i < 4; i++) begin
      send_request(1'b0, 16'h1000, 8'h00);
      send_request(1'b0, 16'h0000, 8'h00);
    end
    send_request(1'b1, 16'hE000, 8'h00);
    send_request(1'b0, 16'h2FFF, 8'h00);
    send_request(1'b0, 16'h4000, 8'h00);
    send_request(1'b0, 16'h7FFF, 8'h00);
    send_request(1'b0, 16'hC000, 8'h00);
    drain();

    // settings, extremes among them
    write_reg(CfgChrCount, 9'd1);
    write_reg(CfgPrgCount, 9'd2);
    write_reg(CfgRamPres, 9'd0);
    random_phase(250);
    drain();
    write_reg(CfgChrCount, 9'd0);
    write_reg(CfgPrgCount, 9'd0);
    write_reg(CfgRamPres, 9'd1);
    random_phase(250);
    drain();
    write_reg(CfgChrCount, 9'd511);
    write_reg(CfgPrgCount, 9'd127);
    random_phase(250);
    drain();
    write_reg(CfgChrCount, 9'd256);
    write_reg(CfgPrgCount, 9'd64);
    random_phase(250);
    drain();
    for (int p = 0; p < 3; p++) begin
      write_reg(CfgChrCount, 9'($urandom));
      write_reg(CfgPrgCount, 9'($urandom));
      write_reg(CfgRamPres, 9'($urandom));
      random_phase(180);
      drain();
    end

    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
